/* rtl/core/ccc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar clock package
// Shared types, limits and calendar helpers for the calendar clock block.
// ----------------------------------------------------------------------------
package ccc_pkg;

	localparam int unsigned YEAR_W      = 14;
	localparam int unsigned LOAD_W      = 7;
	localparam int unsigned COUNT_W     = 32;

	localparam logic [5:0]  SEC_LIMIT   = 6'd60;
	localparam logic [5:0]  MIN_LIMIT   = 6'd60;
	localparam logic [4:0]  HOUR_LIMIT  = 5'd24;
	localparam logic [3:0]  MONTH_LAST  = 4'd12;

	localparam logic [4:0]  LEN_LONG    = 5'd31;
	localparam logic [4:0]  LEN_SHORT   = 5'd30;
	localparam logic [4:0]  LEN_FEB_LEAP = 5'd29;
	localparam logic [4:0]  LEN_FEB     = 5'd28;

	localparam logic [3:0]  MON_FEB     = 4'd2;
	localparam logic [3:0]  MON_APR     = 4'd4;
	localparam logic [3:0]  MON_JUN     = 4'd6;
	localparam logic [3:0]  MON_SEP     = 4'd9;
	localparam logic [3:0]  MON_NOV     = 4'd11;

	localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd2000;
	localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd2099;

	// Configuration register indexes.
	localparam logic CFG_MIN_YEAR = 1'b0;
	localparam logic CFG_MAX_YEAR = 1'b1;

	// Function codes carried on the input tuser.
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;

	typedef struct packed {
		logic [5:0]         second;
		logic [5:0]         minute;
		logic [4:0]         hour;
		logic [4:0]         day;
		logic [3:0]         month;
		logic [YEAR_W-1:0]  year;
		logic [COUNT_W-1:0] countdown;
		logic [COUNT_W-1:0] uptime;
		logic               retired;
	} ccc_state_t;

	typedef struct packed {
		logic [LOAD_W-1:0]  second;
		logic [LOAD_W-1:0]  minute;
		logic [LOAD_W-1:0]  hour;
		logic [LOAD_W-1:0]  day;
		logic [LOAD_W-1:0]  month;
		logic [YEAR_W-1:0]  year;
		logic [COUNT_W-1:0] countdown;
	} ccc_load_t;

	// Gregorian leap year. A year is divisible by 400 exactly when it is
	// divisible by 16 and by 25, so only a test for 25 is needed; that one
	// uses a reciprocal multiply and a multiply back.
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [28:0] prod;
		logic [9:0]  quot;
		logic [13:0] back;
		logic        div25;
		prod  = 29'(y) * 29'd20972;
		quot  = prod[28:19];
		back  = 14'({4'd0, quot} * 14'd25);
		div25 = (back == y);
		return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			MON_FEB: len = leap ? LEN_FEB_LEAP : LEN_FEB;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_SHORT;
			default: len = LEN_LONG;
		endcase
		return len;
	endfunction

endpackage

/* rtl/core/ccc_load_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar clock load check
// Decides whether a requested date and time may be loaded.
// ----------------------------------------------------------------------------
module ccc_load_check (
	input  ccc_pkg::ccc_load_t               load,
	input  logic [ccc_pkg::YEAR_W-1:0]       min_year,
	input  logic [ccc_pkg::YEAR_W-1:0]       max_year,
	output logic                             ok
);
	import ccc_pkg::*;

	logic       year_ok;
	logic       month_ok;
	logic       day_ok;
	logic       time_ok;
	logic [4:0] len;

	assign year_ok  = (load.year >= min_year) && (load.year <= max_year);
	assign month_ok = (load.month >= 7'd1) && (load.month <= {3'd0, MONTH_LAST});
	// The length is only meaningful once the month itself is in range.
	assign len      = month_len(load.month[3:0], is_leap(load.year));
	assign day_ok   = (load.day >= 7'd1) && (load.day <= {2'd0, len});
	assign time_ok  = (load.hour < {2'd0, HOUR_LIMIT}) &&
	                  (load.minute < {1'b0, MIN_LIMIT}) &&
	                  (load.second < {1'b0, SEC_LIMIT});
	assign ok       = year_ok && month_ok && day_ok && time_ok;

endmodule

/* rtl/core/ccc_tick.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar clock tick
// Next state for one second: calendar carry chain, uptime and countdown.
// ----------------------------------------------------------------------------
module ccc_tick (
	input  ccc_pkg::ccc_state_t cur,
	output ccc_pkg::ccc_state_t nxt,
	output logic                alarm
);
	import ccc_pkg::*;

	logic [5:0]         s;
	logic [5:0]         mi;
	logic [4:0]         h;
	logic [5:0]         d;
	logic [3:0]         mo;
	logic [YEAR_W-1:0]  y;
	logic [4:0]         len;
	logic [COUNT_W-1:0] cd;

	assign len = month_len(cur.month, is_leap(cur.year));

	always_comb begin
		s  = cur.second + 6'd1;
		mi = cur.minute;
		h  = cur.hour;
		d  = {1'b0, cur.day};
		mo = cur.month;
		y  = cur.year;
		if (s >= SEC_LIMIT) begin
			s  = 6'd0;
			mi = mi + 6'd1;
		end
		if (mi >= MIN_LIMIT) begin
			mi = 6'd0;
			h  = h + 5'd1;
		end
		if (h >= HOUR_LIMIT) begin
			h = 5'd0;
			d = d + 6'd1;
		end
		if (d > {1'b0, len}) begin
			d  = 6'd1;
			mo = mo + 4'd1;
		end
		if (mo > MONTH_LAST) begin
			d  = 6'd1;
			mo = 4'd1;
			y  = y + 14'd1;
		end
	end

	assign cd = (cur.countdown != '0) ? cur.countdown - 32'd1 : cur.countdown;
	assign alarm = (cd == '0) && !cur.retired;

	always_comb begin
		nxt           = cur;
		nxt.second    = s;
		nxt.minute    = mi;
		nxt.hour      = h;
		nxt.day       = d[4:0];
		nxt.month     = mo;
		nxt.year      = y;
		nxt.countdown = cd;
		nxt.uptime    = cur.uptime + 32'd1;
		nxt.retired   = cur.retired || alarm;
	end

endmodule

/* rtl/core/calendar_clock_with_countdown.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar clock with countdown
// Tick-driven calendar clock with uptime counter and retirement countdown.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while s_tready is high, ticks
// and loads mixed freely, and returns one result per request: the request
// is registered, the clock state is updated from it as the result enters the
// output register, and the result is held there until taken. The result
// shows the state after the request. Each request reads the state left by
// the one before, so the state update sets the rate. A stalled output still
// lets one more request in; tready drops after that.
module calendar_clock_with_countdown (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration write port.
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [ccc_pkg::YEAR_W-1:0]  cfg_data,
	// Request stream.
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// s_tdata: load_second[6:0], load_minute[13:7], load_hour[20:14],
	// load_day[27:21], load_month[34:28], load_year[48:35],
	// load_countdown[80:49], zero fill [87:81].
	input  logic [87:0]                 s_tdata,
	// s_tuser: func[0].
	input  logic                        s_tuser,
	// Result stream.
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// m_tdata: second[5:0], minute[11:6], hour[16:12], day[21:17],
	// month[25:22], year[39:26], countdown[71:40], uptime[103:72],
	// retired[104], alarm_pulse[105], zero fill [111:106].
	output logic [111:0]                m_tdata,
	// m_tuser: status[0].
	output logic                        m_tuser
);
	import ccc_pkg::*;

	logic [YEAR_W-1:0] min_year_q;
	logic [YEAR_W-1:0] max_year_q;

	logic              valid_s1;
	logic              func_s1;
	ccc_load_t         load_s1;

	ccc_state_t        state_q;
	ccc_state_t        tick_state;
	ccc_state_t        load_state;
	ccc_state_t        next_state;
	logic              tick_alarm;
	logic              load_ok;
	logic              advance;
	logic              fire;

	logic              m_valid_q;
	logic [111:0]      m_data_q;
	logic              m_user_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= MIN_YEAR_RST;
			max_year_q <= MAX_YEAR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_YEAR: min_year_q <= cfg_data;
				CFG_MAX_YEAR: max_year_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1           <= s_tuser;
			load_s1.second    <= s_tdata[6:0];
			load_s1.minute    <= s_tdata[13:7];
			load_s1.hour      <= s_tdata[20:14];
			load_s1.day       <= s_tdata[27:21];
			load_s1.month     <= s_tdata[34:28];
			load_s1.year      <= s_tdata[48:35];
			load_s1.countdown <= s_tdata[80:49];
		end
	end

	ccc_tick u_tick (
		.cur   (state_q),
		.nxt   (tick_state),
		.alarm (tick_alarm)
	);

	ccc_load_check u_load_check (
		.load     (load_s1),
		.min_year (min_year_q),
		.max_year (max_year_q),
		.ok       (load_ok)
	);

	always_comb begin
		load_state           = state_q;
		load_state.second    = load_s1.second[5:0];
		load_state.minute    = load_s1.minute[5:0];
		load_state.hour      = load_s1.hour[4:0];
		load_state.day       = load_s1.day[4:0];
		load_state.month     = load_s1.month[3:0];
		load_state.year      = load_s1.year;
		load_state.countdown = load_s1.countdown;
		load_state.retired   = (load_s1.countdown == '0);
	end

	always_comb begin
		if (func_s1 == FUNC_TICK) begin
			next_state = tick_state;
		end else if (load_ok) begin
			next_state = load_state;
		end else begin
			next_state = state_q;
		end
	end

	// Clock state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.second    <= 6'd0;
			state_q.minute    <= 6'd0;
			state_q.hour      <= 5'd12;
			state_q.day       <= 5'd21;
			state_q.month     <= 4'd12;
			state_q.year      <= 14'd2020;
			state_q.countdown <= '0;
			state_q.uptime    <= '0;
			state_q.retired   <= 1'b1;
		end else if (fire) begin
			state_q <= next_state;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_user_q <= (func_s1 == FUNC_LOAD) && !load_ok;
			m_data_q <= {6'd0,
			             (func_s1 == FUNC_TICK) && tick_alarm,
			             next_state.retired,
			             next_state.uptime,
			             next_state.countdown,
			             next_state.year,
			             next_state.month,
			             next_state.day,
			             next_state.hour,
			             next_state.minute,
			             next_state.second};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

`ifndef SYNTH
	// An alarm is only ever reported together with the retired flag and an
	// empty countdown.
	a_alarm_retired: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[105] |-> m_tdata[104] && (m_tdata[71:40] == '0))
		else $error("alarm without retired flag or with countdown left");

	// A rejected load leaves the whole clock state untouched.
	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (func_s1 == FUNC_LOAD) && !load_ok |=> state_q == $past(state_q))
		else $error("rejected load changed the clock state");

	// The retired flag only rises on a processed request.
	a_retired_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q.retired) |-> $past(fire))
		else $error("retired flag rose without a request");

	// The time of day and the month never leave their range, and the day never drops to zero.
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.second < SEC_LIMIT) && (state_q.minute < MIN_LIMIT) &&
		(state_q.hour < HOUR_LIMIT) && (state_q.month >= 4'd1) &&
		(state_q.month <= MONTH_LAST) && (state_q.day >= 5'd1))
		else $error("clock state out of range");
`endif

endmodule

/* tb/calendar_clock_with_countdown_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar clock with countdown testbench
// Drives ticks and loads into the calendar clock over its request stream,
// predicts every result from its own copy of the clock state and year limits,
// and compares each returned result field by field in order of acceptance.
// ----------------------------------------------------------------------------
module calendar_clock_with_countdown_test;

	import ccc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct {
		logic        status;
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [31:0] countdown;
		logic [31:0] uptime;
		logic        retired;
		logic        alarm;
	} clock_reading_t;

	class calendar_scoreboard;
		ccc_state_t        clock_state;
		logic [13:0]       year_lo;
		logic [13:0]       year_hi;
		clock_reading_t    expected_readings[$];
		int unsigned       error_count;

		function new();
			clock_state.second    = 6'd0;
			clock_state.minute    = 6'd0;
			clock_state.hour      = 5'd12;
			clock_state.day       = 5'd21;
			clock_state.month     = 4'd12;
			clock_state.year      = 14'd2020;
			clock_state.countdown = 32'd0;
			clock_state.uptime    = 32'd0;
			clock_state.retired   = 1'b1;
			year_lo     = 14'd2000;
			year_hi     = 14'd2099;
			error_count = 0;
		endfunction

		function void set_limit(logic index, logic [13:0] value);
			if (index == CFG_MIN_YEAR) begin
				year_lo = value;
			end else begin
				year_hi = value;
			end
		endfunction

		function bit leap_year(int unsigned y);
			return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		endfunction

		function int unsigned month_length(int unsigned m, int unsigned y);
			if (m == 2) begin
				return leap_year(y) ? 29 : 28;
			end
			if (m == 4 || m == 6 || m == 9 || m == 11) begin
				return 30;
			end
			return 31;
		endfunction

		function int unsigned pending();
			return expected_readings.size();
		endfunction

		// Advances the clock by one second; returns 1 when retirement begins.
		function logic advance_second();
			int unsigned sec;
			int unsigned mn;
			int unsigned hr;
			int unsigned dy;
			int unsigned mo;
			int unsigned yr;
			logic        alarm;
			alarm = 1'b0;
			sec = clock_state.second;
			mn  = clock_state.minute;
			hr  = clock_state.hour;
			dy  = clock_state.day;
			mo  = clock_state.month;
			yr  = clock_state.year;
			clock_state.uptime = clock_state.uptime + 32'd1;
			if (clock_state.countdown != 32'd0) begin
				clock_state.countdown = clock_state.countdown - 32'd1;
			end
			sec++;
			if (sec >= 60) begin
				sec = 0;
				mn++;
			end
			if (mn >= 60) begin
				mn = 0;
				hr++;
			end
			if (hr >= 24) begin
				hr = 0;
				dy++;
			end
			if (dy > month_length(mo, yr)) begin
				dy = 1;
				mo++;
			end
			if (mo > 12) begin
				dy = 1;
				mo = 1;
				yr = (yr + 1) % 16384;
			end
			clock_state.second = sec[5:0];
			clock_state.minute = mn[5:0];
			clock_state.hour   = hr[4:0];
			clock_state.day    = dy[4:0];
			clock_state.month  = mo[3:0];
			clock_state.year   = yr[13:0];
			if (clock_state.countdown == 32'd0 && !clock_state.retired) begin
				clock_state.retired = 1'b1;
				alarm = 1'b1;
			end
			return alarm;
		endfunction

		function void note_request(logic func, logic [87:0] data);
			ccc_load_t      ld;
			clock_reading_t rd;
			bit             valid;
			ld.second    = data[6:0];
			ld.minute    = data[13:7];
			ld.hour      = data[20:14];
			ld.day       = data[27:21];
			ld.month     = data[34:28];
			ld.year      = data[48:35];
			ld.countdown = data[80:49];
			rd.status = 1'b0;
			rd.alarm  = 1'b0;
			if (func == FUNC_TICK) begin
				rd.alarm = advance_second();
			end else begin
				valid = (ld.year >= year_lo) && (ld.year <= year_hi) &&
					(ld.month >= 1) && (ld.month <= 12) && (ld.day >= 1) &&
					(ld.day <= month_length(ld.month, ld.year)) &&
					(ld.hour <= 23) && (ld.minute <= 59) && (ld.second <= 59);
				if (valid) begin
					clock_state.second    = ld.second[5:0];
					clock_state.minute    = ld.minute[5:0];
					clock_state.hour      = ld.hour[4:0];
					clock_state.day       = ld.day[4:0];
					clock_state.month     = ld.month[3:0];
					clock_state.year      = ld.year;
					clock_state.countdown = ld.countdown;
					clock_state.retired   = (ld.countdown == 32'd0);
				end else begin
					rd.status = 1'b1;
				end
			end
			rd.second    = clock_state.second;
			rd.minute    = clock_state.minute;
			rd.hour      = clock_state.hour;
			rd.day       = clock_state.day;
			rd.month     = clock_state.month;
			rd.year      = clock_state.year;
			rd.countdown = clock_state.countdown;
			rd.uptime    = clock_state.uptime;
			rd.retired   = clock_state.retired;
			expected_readings.push_back(rd);
		endfunction

		function void compare_field(string name, longint unsigned want,
				longint unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, name, want, got);
				error_count++;
			end
		endfunction

		function void check_reading(logic [111:0] data, logic status);
			clock_reading_t rd;
			if (expected_readings.size() == 0) begin
				$display("%0t: result with no request outstanding, actual %h",
					$time, data);
				error_count++;
				return;
			end
			rd = expected_readings.pop_front();
			compare_field("status", rd.status, status);
			compare_field("second", rd.second, data[5:0]);
			compare_field("minute", rd.minute, data[11:6]);
			compare_field("hour", rd.hour, data[16:12]);
			compare_field("day", rd.day, data[21:17]);
			compare_field("month", rd.month, data[25:22]);
			compare_field("year", rd.year, data[39:26]);
			compare_field("countdown", rd.countdown, data[71:40]);
			compare_field("uptime", rd.uptime, data[103:72]);
			compare_field("retired", rd.retired, data[104]);
			compare_field("alarm_pulse", rd.alarm, data[105]);
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          cfg_we;
	logic          cfg_index;
	logic [13:0]   cfg_data;
	logic          s_tvalid;
	logic          s_tready;
	logic [87:0]   s_tdata;
	logic          s_tuser;
	logic          m_tvalid;
	logic          m_tready;
	logic [111:0]  m_tdata;
	logic          m_tuser;

	calendar_scoreboard calendar_sb;
	int unsigned        send_idle_pct;
	int unsigned        recv_idle_pct;
	bit                 hold_req;
	int unsigned        hold_left;
	int unsigned        cycle_count;

	calendar_clock_with_countdown DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #2 clk = ~clk;

	// Result side: random stalls, and a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 150;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				calendar_sb.note_request(s_tuser, s_tdata);
			end
			if (m_tvalid && m_tready) begin
				calendar_sb.check_reading(m_tdata, m_tuser);
			end
		end
	end

	task automatic send_request(logic func, logic [87:0] data);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic tick_request();
		send_request(FUNC_TICK, 88'd0);
	endtask

	task automatic load_request(int unsigned s, int unsigned mi, int unsigned h,
			int unsigned d, int unsigned mo, int unsigned y, logic [31:0] cd);
		send_request(FUNC_LOAD, {7'd0, cd, 14'(y), 7'(mo), 7'(d), 7'(h),
			7'(mi), 7'(s)});
	endtask

	// Stops offering requests until every outstanding result has come back.
	// The first edge lets the last accepted request be noted before counting.
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (calendar_sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_year_limits(logic [13:0] lo, logic [13:0] hi);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MIN_YEAR;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= CFG_MAX_YEAR;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		calendar_sb.set_limit(CFG_MIN_YEAR, lo);
		calendar_sb.set_limit(CFG_MAX_YEAR, hi);
	endtask

	task automatic random_request();
		int unsigned pick;
		int unsigned lo;
		int unsigned hi;
		int unsigned len;
		int unsigned s;
		int unsigned mi;
		int unsigned h;
		int unsigned d;
		int unsigned mo;
		int unsigned y;
		logic [31:0] cd;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			tick_request();
			return;
		end
		if (pick < 72) begin
			load_request($urandom_range(0, 99), $urandom_range(0, 99),
				$urandom_range(0, 99), $urandom_range(0, 99),
				$urandom_range(0, 99), $urandom_range(0, 9999), $urandom);
			return;
		end
		lo = (calendar_sb.year_lo <= calendar_sb.year_hi) ?
			calendar_sb.year_lo : calendar_sb.year_hi;
		hi = (calendar_sb.year_lo <= calendar_sb.year_hi) ?
			calendar_sb.year_hi : calendar_sb.year_lo;
		case ($urandom_range(0, 4))
			0: y = lo;
			1: y = hi;
			2: y = ($urandom_range(lo, hi) / 100) * 100;
			default: y = $urandom_range(lo, hi);
		endcase
		if (y < lo) begin
			y = lo;
		end
		mo = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(1, 12);
		len = calendar_sb.month_length(mo, y);
		// Land near the end of a minute, hour, day or month to exercise carries.
		s  = ($urandom_range(0, 1) != 0) ? $urandom_range(55, 59) : $urandom_range(0, 59);
		mi = ($urandom_range(0, 1) != 0) ? 59 : $urandom_range(0, 59);
		h  = ($urandom_range(0, 1) != 0) ? 23 : $urandom_range(0, 23);
		d  = ($urandom_range(0, 1) != 0) ? len - $urandom_range(0, 1) :
			$urandom_range(1, len);
		case ($urandom_range(0, 4))
			0: cd = 32'd0;
			1: cd = 32'd1;
			2: cd = $urandom_range(2, 400);
			3: cd = 32'hFFFF_FFFF;
			default: cd = $urandom;
		endcase
		if (pick >= 90) begin
			case ($urandom_range(0, 6))
				0: d = len + 1;
				1: d = 0;
				2: mo = ($urandom_range(0, 1) != 0) ? 13 : 0;
				3: h = 24;
				4: mi = 60;
				5: s = 60;
				default: y = (hi < 9999) ? hi + 1 : ((lo > 0) ? lo - 1 : 9999);
			endcase
		end
		load_request(s, mi, h, d, mo, y, cd);
	endtask

	initial begin
		logic [13:0] seg_lo[6];
		logic [13:0] seg_hi[6];
		seg_lo = '{14'd0, 14'd1583, 14'd2000, 14'd9999, 14'd2024, 14'd1890};
		seg_hi = '{14'd9999, 14'd2400, 14'd2099, 14'd0, 14'd2024, 14'd2110};
		calendar_sb = new();
		clk         = 1'b0;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_MIN_YEAR;
		cfg_data    = 14'd0;
		s_tvalid    = 1'b0;
		s_tdata     = 88'd0;
		s_tuser     = FUNC_TICK;
		m_tready    = 1'b0;
		hold_req    = 1'b0;
		hold_left   = 0;
		cycle_count = 0;
		send_idle_pct = 36;
		recv_idle_pct = 69;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests under the year limits left by reset.
		tick_request();
		load_request(59, 59, 23, 31, 12, 2099, 32'd1);
		tick_request();
		tick_request();
		load_request(59, 59, 23, 29, 2, 2000, 32'hFFFF_FFFF);
		tick_request();
		load_request(0, 0, 0, 29, 2, 2099, 32'd5);
		load_request(59, 59, 23, 28, 2, 2001, 32'd0);
		tick_request();
		load_request(59, 59, 23, 30, 4, 2010, 32'd2);
		tick_request();
		load_request(0, 0, 0, 31, 4, 2010, 32'd2);
		load_request(59, 59, 23, 31, 1, 2050, 32'd0);
		tick_request();
		load_request(0, 0, 0, 1, 1, 1999, 32'd3);
		load_request(0, 0, 0, 1, 1, 2100, 32'd3);
		load_request(0, 0, 0, 1, 0, 2050, 32'd3);
		load_request(0, 0, 0, 1, 13, 2050, 32'd3);
		load_request(0, 0, 0, 0, 6, 2050, 32'd3);
		load_request(0, 0, 24, 1, 6, 2050, 32'd3);
		load_request(0, 60, 0, 1, 6, 2050, 32'd3);
		load_request(60, 0, 0, 1, 6, 2050, 32'd3);
		load_request(99, 99, 99, 99, 99, 9999, 32'hFFFF_FFFF);
		wait_results_drained();

		// Widest limits: year zero counts as a leap year, 1900 does not.
		write_year_limits(14'd0, 14'd9999);
		load_request(0, 0, 0, 29, 2, 0, 32'd1);
		load_request(0, 0, 0, 29, 2, 1900, 32'd1);
		load_request(59, 59, 23, 31, 12, 9999, 32'd1);
		tick_request();

		for (int seg = 0; seg < 6; seg++) begin
			wait_results_drained();
			write_year_limits(seg_lo[seg], seg_hi[seg]);
			case (seg / 2)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 69;
				end
				1: begin
					send_idle_pct = 69;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (seg == 4) begin
				hold_req = 1'b1;
			end
			for (int n = 0; n < 165; n++) begin
				if (n == 80) begin
					wait_results_drained();
				end
				random_request();
			end
		end

		wait_results_drained();
		repeat (8) @(posedge clk);
		if (calendar_sb.error_count == 0 && calendar_sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
